@@ rtl/spsel_pkg.sv @@
package spsel_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int FIELD_BITS = 32;
   localparam int DIM_BITS = 11;
   localparam int PCT_BITS = 17;
   localparam int PCT_FRAC = 16;
   localparam logic [PCT_BITS-1:0] ONE_Q16 = 17'd65536;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

endpackage

@@ rtl/sorted_percentile_select.sv @@
// A load request is inserted into the cell row once no query is left in the row.
// A query passes the s1 register, each cell's token register and then the rsp register.
// Requests of one kind are taken one per cycle, queries only while the row moves; a load
// after a query waits for the row to empty. Reset clears the control registers, the loaded
// count and the valid bit of every cell; the stored samples themselves are not cleared.
module sorted_percentile_select import spsel_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [FIELD_BITS-1:0]     req_sample,
   input  logic [PCT_BITS-1:0]       req_percent,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FIELD_BITS-1:0]     rsp_selected_value,
   output logic                      rsp_query_error,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int FLIGHT_W = $clog2(MAX_SAMPLES + 2);

   logic                   load_en;
   logic [SAMPLE_BITS-1:0] load_key;
   logic                   inject_valid;
   logic [IDX_W-1:0]       inject_index;
   logic                   inject_error;
   logic [CNT_W-1:0]       loaded_count;
   logic                   chain_advance;

   logic [SAMPLE_BITS-1:0] cell_value [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] cell_valid;
   logic [MAX_SAMPLES-1:0] cell_take;

   logic [MAX_SAMPLES:0]   tok_valid;
   logic [IDX_W-1:0]       tok_index [MAX_SAMPLES+1];
   logic [MAX_SAMPLES:0]   tok_error;
   logic [SAMPLE_BITS-1:0] tok_data [MAX_SAMPLES+1];

   logic                   rsp_valid_ff;
   logic [FIELD_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_error_ff;
   logic [FIELD_BITS-1:0]  exit_value;

   assign chain_advance = !rsp_valid_ff || !rsp_stall;

   spsel_front #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W(CNT_W),
      .IDX_W(IDX_W),
      .FLIGHT_W(FLIGHT_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_sample(req_sample),
      .req_percent(req_percent),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .chain_advance(chain_advance),
      .chain_exit(tok_valid[MAX_SAMPLES]),
      .load_en(load_en),
      .load_key(load_key),
      .inject_valid(inject_valid),
      .inject_index(inject_index),
      .inject_error(inject_error),
      .loaded_count(loaded_count)
   );

   assign tok_valid[0] = inject_valid;
   assign tok_index[0] = inject_index;
   assign tok_error[0] = inject_error;
   assign tok_data[0] = '0;

   generate
      for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
         logic [SAMPLE_BITS-1:0] left_value;
         logic                   left_valid;
         logic                   left_take;
         if (k == 0) begin : g_head
            assign left_value = load_key;
            assign left_valid = 1'b1;
            assign left_take = 1'b0;
         end else begin : g_body
            assign left_value = cell_value[k-1];
            assign left_valid = cell_valid[k-1];
            assign left_take = cell_take[k-1];
         end
         spsel_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .IDX_W(IDX_W),
            .POS(k)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .load_en(load_en),
            .load_key(load_key),
            .left_value(left_value),
            .left_valid(left_valid),
            .left_take(left_take),
            .value(cell_value[k]),
            .valid(cell_valid[k]),
            .take(cell_take[k]),
            .tok_advance(chain_advance),
            .tok_in_valid(tok_valid[k]),
            .tok_in_index(tok_index[k]),
            .tok_in_error(tok_error[k]),
            .tok_in_data(tok_data[k]),
            .tok_out_valid(tok_valid[k+1]),
            .tok_out_index(tok_index[k+1]),
            .tok_out_error(tok_error[k+1]),
            .tok_out_data(tok_data[k+1])
         );
      end
   endgenerate

   generate
      if (SAMPLE_BITS >= FIELD_BITS) begin : g_out_wide
         assign exit_value = tok_data[MAX_SAMPLES][FIELD_BITS-1:0];
      end else begin : g_out_narrow
         assign exit_value = FIELD_BITS'(tok_data[MAX_SAMPLES]);
      end
   endgenerate

   assign rsp_value_in = tok_error[MAX_SAMPLES] ? '0 : exit_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_advance) begin
         rsp_valid_ff <= tok_valid[MAX_SAMPLES];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= tok_error[MAX_SAMPLES];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_selected_value = rsp_value_ff;
   assign rsp_query_error = rsp_error_ff;

   // The occupied cells always match the number of samples loaded.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(loaded_count))
      else $error("cell valid bits disagree with loaded count");

   // No sample is inserted while a query is still reading the cells.
   a_load_row_quiet: assert property (@(posedge clock) disable iff (reset)
      load_en |-> (tok_valid[MAX_SAMPLES:1] == '0))
      else $error("sample inserted while a query was in the row");

   // A query enters the row only on a cycle in which the row moves.
   a_inject_moves: assert property (@(posedge clock) disable iff (reset)
      inject_valid |-> chain_advance)
      else $error("query entered a stalled row");

endmodule

@@ rtl/spsel_cell.sv @@
module spsel_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int IDX_W = 10,
   parameter int POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_en,
   input  logic [SAMPLE_BITS-1:0] load_key,
   input  logic [SAMPLE_BITS-1:0] left_value,
   input  logic                   left_valid,
   input  logic                   left_take,
   output logic [SAMPLE_BITS-1:0] value,
   output logic                   valid,
   output logic                   take,
   input  logic                   tok_advance,
   input  logic                   tok_in_valid,
   input  logic [IDX_W-1:0]       tok_in_index,
   input  logic                   tok_in_error,
   input  logic [SAMPLE_BITS-1:0] tok_in_data,
   output logic                   tok_out_valid,
   output logic [IDX_W-1:0]       tok_out_index,
   output logic                   tok_out_error,
   output logic [SAMPLE_BITS-1:0] tok_out_data
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   tok_valid_ff;
   logic [IDX_W-1:0]       tok_index_ff;
   logic                   tok_error_ff;
   logic [SAMPLE_BITS-1:0] tok_data_ff, tok_data_in;

   // An empty cell or one holding a larger value gives way to the new key.
   assign take = !valid_ff || ($signed(value_ff) > $signed(load_key));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (load_en && take) begin
         if (left_take) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = load_key;
            valid_in = 1'b1;
         end
      end
   end

   assign tok_data_in = (tok_in_index == IDX_W'(POS)) ? value_ff : tok_in_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (tok_advance) begin
            tok_valid_ff <= tok_in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (tok_advance) begin
         tok_index_ff <= tok_in_index;
         tok_error_ff <= tok_in_error;
         tok_data_ff <= tok_data_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign tok_out_valid = tok_valid_ff;
   assign tok_out_index = tok_index_ff;
   assign tok_out_error = tok_error_ff;
   assign tok_out_data = tok_data_ff;

endmodule

@@ rtl/spsel_front.sv @@
module spsel_front import spsel_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CNT_W = $clog2(MAX_SAMPLES + 1),
   parameter int IDX_W = $clog2(MAX_SAMPLES),
   parameter int FLIGHT_W = $clog2(MAX_SAMPLES + 2)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [FIELD_BITS-1:0]     req_sample,
   input  logic [PCT_BITS-1:0]       req_percent,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_wdata,
   input  logic                      chain_advance,
   input  logic                      chain_exit,
   output logic                      load_en,
   output logic [SAMPLE_BITS-1:0]    load_key,
   output logic                      inject_valid,
   output logic [IDX_W-1:0]          inject_index,
   output logic                      inject_error,
   output logic [CNT_W-1:0]          loaded_count
);

   localparam int PROD_W = 2 * DIM_BITS;
   localparam int QP_W = CNT_W + PCT_BITS;

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PROD_W-1:0]     dims_prod;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic [FLIGHT_W-1:0]   flight_ff, flight_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff;
   logic [FIELD_BITS-1:0] s1_sample_ff;
   logic [PCT_BITS-1:0]   s1_percent_ff;
   logic                  go, accept;
   logic [QP_W-1:0]       idx_prod;
   logic [CNT_W:0]        idx_full;
   logic [CNT_W-1:0]      idx_clamped;
   logic [CNT_W-1:0]      count_m1;

   assign dims_prod = width_ff * height_ff;
   assign count_in = (dims_prod > PROD_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                        : CNT_W'(dims_prod);

   // A load changes the cells, so it waits until no query is travelling the chain.
   assign go = s1_valid_ff && ((s1_op_ff == OP_LOAD) ? (flight_ff == '0) : chain_advance);
   assign req_stall = s1_valid_ff && !go;
   assign accept = req_valid && !req_stall;
   assign s1_valid_in = accept ? 1'b1 : (go ? 1'b0 : s1_valid_ff);

   assign load_en = go && (s1_op_ff == OP_LOAD) && (loaded_ff < count_ff);
   assign loaded_in = load_en ? loaded_ff + 1'b1 : loaded_ff;

   generate
      if (SAMPLE_BITS <= FIELD_BITS) begin : g_key_narrow
         assign load_key = s1_sample_ff[SAMPLE_BITS-1:0];
      end else begin : g_key_wide
         assign load_key = SAMPLE_BITS'(s1_sample_ff);
      end
   endgenerate

   assign idx_prod = QP_W'(count_ff) * QP_W'(s1_percent_ff);
   assign idx_full = idx_prod[PCT_FRAC +: CNT_W + 1];
   assign count_m1 = count_ff - 1'b1;
   assign idx_clamped = (idx_full >= {1'b0, count_ff}) ? count_m1 : idx_full[CNT_W-1:0];

   assign inject_valid = go && (s1_op_ff == OP_QUERY);
   assign inject_index = idx_clamped[IDX_W-1:0];
   assign inject_error = (s1_percent_ff > ONE_Q16) || (loaded_ff == '0) || (count_ff == '0);

   always_comb begin
      flight_in = flight_ff;
      if (inject_valid && !(chain_exit && chain_advance)) begin
         flight_in = flight_ff + 1'b1;
      end else if (!inject_valid && chain_exit && chain_advance) begin
         flight_in = flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         height_ff <= '0;
         count_ff <= '0;
         loaded_ff <= '0;
         flight_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_IMAGE_WIDTH)) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_IMAGE_HEIGHT)) begin
            height_ff <= csr_wdata;
         end
         count_ff <= count_in;
         loaded_ff <= loaded_in;
         flight_ff <= flight_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= req_opcode;
         s1_sample_ff <= req_sample;
         s1_percent_ff <= req_percent;
      end
   end

   assign loaded_count = loaded_ff;

endmodule
